// ===== rtl/tst_pkg.sv =====
// Shared types and constants for the touch stroke tracker.
package tst_pkg;

  typedef struct packed {
    logic               action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [31:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               restarted;
    logic        [15:0] count;
    logic               enough;
    logic               gesture_on;
    logic        [31:0] path_length;
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_max_y;
    logic        [31:0] span_ms;
  } out_item_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP_SQ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP_MS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_FACTOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS  = 3'd5;

  localparam logic [19:0] RST_MIN_STEP_SQ = 20'd16;
  localparam logic [15:0] RST_MAX_GAP_MS  = 16'd100;
  localparam logic [19:0] RST_MIN_LENGTH  = 20'd800;
  localparam logic [15:0] RST_SPEED_LIMIT = 16'd1000;
  localparam logic [9:0]  RST_AVG_FACTOR  = 10'd256;
  localparam logic [7:0]  RST_MIN_POINTS  = 8'd4;

  localparam logic        ACT_CLEAR = 1'b1;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [31:0] MS_PER_S  = 32'd1000;
  localparam logic [31:0] MS_AVG    = 32'd256000;

endpackage

// ===== rtl/tst_chan_if.sv =====
// Valid/ready channel interface carrying one payload item.
interface tst_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/touch_stroke_tracker.sv =====
// Touch stroke tracker top level: sequencer, shared multiplier and stroke state.
//
//  channel  | dir | handshake            | payload
//  in_s     | in  | valid/ready          | action, pos_x, pos_y, stamp
//  out_s    | out | valid/ready          | stroke figures, one per input
//  cfg_*    | in  | cfg_wr_en, no stall  | cfg_index, cfg_wdata
//
// A clear or a duplicate passes S_G1 to S_G4; a kept sample after the first point runs
// S_ROOT first, and the second point also passes S_FS1 to S_FS3 before the S_G states.
// The sequencer uses the bit-serial square root and one shared 32x32 multiplier.
// in_s.ready is high only while the sequencer is idle; a result waits in the output
// register, and a new transfer is taken meanwhile. rst_n is synchronous, active low.
module touch_stroke_tracker
  import tst_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tst_chan_if.sink              in_s,
  tst_chan_if.source            out_s,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW   = (COORD_BITS > 16) ? 17 : COORD_BITS;
  localparam int D2W  = 2 * CW + 1;
  localparam int VW   = 2 * CW + 2 + 2 * FRAC_BITS;
  localparam int RW   = VW / 2;
  localparam int CMPW = (D2W > 20) ? D2W : 20;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_DUP, S_ROOT, S_FS1, S_FS2, S_FS3,
    S_G1, S_G2, S_G3, S_G4
  } state_t;

  state_t state_r;

  // configuration
  logic [19:0] min_step_r;
  logic [15:0] max_gap_r;
  logic [19:0] min_len_r;
  logic [15:0] speed_r;
  logic [9:0]  avg_r;
  logic [7:0]  min_pts_r;

  // stroke state
  logic [15:0]          cnt_r;
  logic signed [CW-1:0] px_r, py_r;
  logic [31:0]          ptime_r, stime_r;
  logic [31:0]          len_r;
  logic                 fast_r;
  logic signed [CW-1:0] lox_r, loy_r, hix_r, hiy_r;
  logic                 acc_flag_r, rst_flag_r, first_seg_r;

  // work registers
  logic signed [CW-1:0] ix_r, iy_r;
  logic [31:0]          it_r;
  logic [CW-1:0]        ax_r, ay_r;
  logic signed [32:0]   dt_r;
  logic [RW-1:0]        seg_r;
  logic [63:0]          prod_r, acc_r, lhs_r;

  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic signed [CW-1:0] x_in, y_in;
  logic signed [CW:0]   dx, dy;
  logic [CW-1:0]        ax, ay;
  logic [D2W-1:0]       d2;
  logic                 dup, gap;
  logic signed [32:0]   dt;
  logic [31:0]          mul_a, mul_b;
  logic [31:0]          span;
  logic [15:0]          cnt_inc;
  logic [32:0]          len_sum;
  logic                 gest;
  logic                 in_fire, out_free;
  logic                 root_start, root_done;
  logic [RW-1:0]        root;

  generate
    if (COORD_BITS > 16) begin : g_wide
      assign x_in = {1'b0, in_s.data.pos_x};
      assign y_in = {1'b0, in_s.data.pos_y};
    end else begin : g_narrow
      assign x_in = in_s.data.pos_x[CW-1:0];
      assign y_in = in_s.data.pos_y[CW-1:0];
    end
  endgenerate

  assign in_s.ready = (state_r == S_IDLE);
  assign in_fire    = in_s.valid && in_s.ready;
  assign out_free   = !out_valid_r || out_s.ready;

  always_comb begin
    dx = {x_in[CW-1], x_in} - {px_r[CW-1], px_r};
    dy = {y_in[CW-1], y_in} - {py_r[CW-1], py_r};
    ax = dx[CW] ? CW'(-dx) : CW'(dx);
    ay = dy[CW] ? CW'(-dy) : CW'(dy);
    d2 = D2W'(acc_r[2*CW-1:0]) + D2W'(prod_r[2*CW-1:0]);
    dup = (cnt_r != 16'd0) && (CMPW'(d2) < CMPW'(min_step_r));
    dt  = $signed({1'b0, it_r}) - $signed({1'b0, ptime_r});
    gap = (cnt_r != 16'd0) && (dt > $signed({17'd0, max_gap_r}));
    span = ((cnt_r < 16'd2) || (ptime_r < stime_r)) ? 32'd0 : ptime_r - stime_r;
    cnt_inc = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 16'd1;
    len_sum = {1'b0, len_r} + 33'(root);
    if (cnt_r < 16'd2 || len_r < 32'(min_len_r)) begin
      gest = 1'b0;
    end else if (fast_r) begin
      gest = 1'b1;
    end else if (span == 32'd0) begin
      gest = (acc_r == 64'd0);
    end else begin
      gest = (lhs_r >= prod_r);
    end
  end

  assign root_start = (state_r == S_DUP) && !dup && !gap && (cnt_r != 16'd0);

  tst_isqrt #(.VW(VW)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (VW'(d2) << (2 * FRAC_BITS)),
    .done  (root_done),
    .root  (root)
  );

  always_comb begin
    unique case (state_r) inside
      S_SQX: begin
        mul_a = 32'(ax_r);
        mul_b = 32'(ax_r);
      end
      S_SQY: begin
        mul_a = 32'(ay_r);
        mul_b = 32'(ay_r);
      end
      S_FS1: begin
        mul_a = 32'(seg_r);
        mul_b = MS_PER_S;
      end
      S_FS2: begin
        mul_a = 32'(speed_r);
        mul_b = 32'(dt_r[15:0]);
      end
      S_G1: begin
        mul_a = 32'(speed_r);
        mul_b = 32'(avg_r);
      end
      S_G2: begin
        mul_a = len_r;
        mul_b = MS_AVG;
      end
      S_G3, S_G4: begin
        mul_a = acc_r[31:0];
        mul_b = span;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (in_fire) begin
      ix_r <= x_in;
      iy_r <= y_in;
      it_r <= in_s.data.stamp;
      ax_r <= ax;
      ay_r <= ay;
    end
    case (state_r)
      S_SQY: acc_r <= prod_r;
      S_DUP: dt_r <= dt;
      S_ROOT: if (root_done) seg_r <= root;
      S_FS2: acc_r <= prod_r >> FRAC_BITS;
      S_G2: acc_r <= prod_r;
      S_G3: lhs_r <= prod_r >> FRAC_BITS;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_step_r <= RST_MIN_STEP_SQ;
      max_gap_r  <= RST_MAX_GAP_MS;
      min_len_r  <= RST_MIN_LENGTH;
      speed_r    <= RST_SPEED_LIMIT;
      avg_r      <= RST_AVG_FACTOR;
      min_pts_r  <= RST_MIN_POINTS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_STEP_SQ: min_step_r <= cfg_wdata;
        CFG_MAX_GAP_MS:  max_gap_r  <= cfg_wdata[15:0];
        CFG_MIN_LENGTH:  min_len_r  <= cfg_wdata;
        CFG_SPEED_LIMIT: speed_r    <= cfg_wdata[15:0];
        CFG_AVG_FACTOR:  avg_r      <= cfg_wdata[9:0];
        CFG_MIN_POINTS:  min_pts_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      px_r        <= '0;
      py_r        <= '0;
      ptime_r     <= '0;
      stime_r     <= '0;
      len_r       <= '0;
      fast_r      <= 1'b0;
      lox_r       <= '0;
      loy_r       <= '0;
      hix_r       <= '0;
      hiy_r       <= '0;
      acc_flag_r  <= 1'b0;
      rst_flag_r  <= 1'b0;
      first_seg_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (out_valid_r && out_s.ready && state_r != S_G4) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            acc_flag_r <= 1'b0;
            rst_flag_r <= 1'b0;
            if (in_s.data.action == ACT_CLEAR) begin
              cnt_r   <= '0;
              px_r    <= '0;
              py_r    <= '0;
              ptime_r <= '0;
              stime_r <= '0;
              len_r   <= '0;
              fast_r  <= 1'b0;
              lox_r   <= '0;
              loy_r   <= '0;
              hix_r   <= '0;
              hiy_r   <= '0;
              state_r <= S_G1;
            end else begin
              state_r <= S_SQX;
            end
          end
        end
        S_SQX: state_r <= S_SQY;
        S_SQY: state_r <= S_DUP;
        S_DUP: begin
          if (dup) begin
            state_r <= S_G1;
          end else begin
            acc_flag_r <= 1'b1;
            px_r       <= ix_r;
            py_r       <= iy_r;
            ptime_r    <= it_r;
            if (gap || cnt_r == 16'd0) begin
              // stroke starts over at this point
              rst_flag_r <= gap;
              cnt_r      <= 16'd1;
              stime_r    <= it_r;
              len_r      <= '0;
              fast_r     <= 1'b0;
              lox_r      <= ix_r;
              hix_r      <= ix_r;
              loy_r      <= iy_r;
              hiy_r      <= iy_r;
              state_r    <= S_G1;
            end else begin
              cnt_r       <= cnt_inc;
              first_seg_r <= (cnt_r == 16'd1);
              if (ix_r < lox_r) lox_r <= ix_r;
              if (ix_r > hix_r) hix_r <= ix_r;
              if (iy_r < loy_r) loy_r <= iy_r;
              if (iy_r > hiy_r) hiy_r <= iy_r;
              state_r <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (root_done) begin
            len_r   <= len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
            state_r <= first_seg_r ? S_FS1 : S_G1;
          end
        end
        S_FS1: state_r <= S_FS2;
        S_FS2: state_r <= S_FS3;
        S_FS3: begin
          if (dt_r[32] || dt_r == 33'sd0) begin
            fast_r <= (speed_r == 16'd0);
          end else begin
            fast_r <= (acc_r >= prod_r);
          end
          state_r <= S_G1;
        end
        S_G1: state_r <= S_G2;
        S_G2: state_r <= S_G3;
        S_G3: state_r <= S_G4;
        S_G4: begin
          if (out_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.accepted     <= acc_flag_r;
            out_data_r.restarted    <= rst_flag_r;
            out_data_r.count        <= cnt_r;
            out_data_r.enough       <= (cnt_r >= {8'd0, min_pts_r});
            out_data_r.gesture_on   <= gest;
            out_data_r.path_length  <= len_r;
            out_data_r.box_min_x    <= 16'(lox_r);
            out_data_r.box_min_y    <= 16'(loy_r);
            out_data_r.box_max_x    <= 16'(hix_r);
            out_data_r.box_max_y    <= 16'(hiy_r);
            out_data_r.span_ms      <= span;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

`ifndef SYNTHESIS
  a_busy_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE) else $error("sequencer idle after input transfer");
  a_restart_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.data.restarted |-> out_s.data.accepted)
    else $error("restart reported on a dropped sample");
  a_gesture_points: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.data.gesture_on |-> out_s.data.count > 16'd1)
    else $error("gesture with fewer than two points");
  a_kept_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.data.accepted |-> out_s.data.count != 16'd0)
    else $error("kept sample with empty stroke");
`endif

endmodule

// ===== rtl/tst_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module tst_isqrt
  import tst_pkg::*;
#(
  parameter int VW = 36
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VW-1:0]     value,
  output logic              done,
  output logic [VW/2-1:0]   root
);

  localparam logic [VW-1:0] TOP_BIT = VW'(1) << (VW - 2);

  logic          busy_r;
  logic          done_r;
  logic [VW-1:0] v_r;
  logic [VW-1:0] r_r;
  logic [VW-1:0] bit_r;
  logic [VW-1:0] trial;
  logic          ge;

  always_comb begin
    trial = r_r + bit_r;
    ge    = (v_r >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      r_r   <= '0;
      bit_r <= TOP_BIT;
    end else if (busy_r) begin
      if (ge) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[VW/2-1:0];

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("isqrt not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("isqrt done while busy");
  a_done_prev: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("isqrt done without work");
  a_busy_bit: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(start) |-> bit_r != '0) else $error("isqrt ran past last bit");
`endif

endmodule
